[src/asa_pkg.sv]
// Shared types and codes for the aligned stack allocator.
// Depends on nothing; every other file in src imports it.
package asa_pkg;

   // Request kinds
   localparam logic [1:0] KIND_ALLOC    = 2'd0;
   localparam logic [1:0] KIND_FREE     = 2'd1;
   localparam logic [1:0] KIND_FAST     = 2'd2;
   localparam logic [1:0] KIND_ROLLBACK = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OOM     = 3'd1;
   localparam logic [2:0] ST_NOT_TOP = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // Largest pool in bytes
   localparam logic [16:0] POOL_MAX = 17'h10000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] size;
      logic [7:0]  alignment;
      logic [15:0] address;
   } asa_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_address;
   } asa_rsp_type;

   // Source of the result address
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ECHO,
      SEL_POPPED,
      SEL_BLOCK
   } asa_addr_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;
      logic             push;
      logic             pop;
      logic             finish;
      logic [2:0]       status;
      asa_addr_sel_type addr_sel;
   } asa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] kind;
      logic       empty;
      logic       full;
      logic       last;
      logic       oom;
      logic       top_match;
      logic       pop_match;
   } asa_sts_type;

endpackage

[src/asa_dpath.sv]
// Datapath of the aligned stack allocator: request latch, pool size, top
// offset, entry count, entry stack memory and result register. Uses asa_pkg.
module asa_dpath #(
   parameter int MAX_DEPTH    = 64,
   parameter int HEADER_BYTES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  asa_pkg::asa_req_type req_data,
   input  logic                csr_write,
   input  logic [16:0]         csr_data,
   input  asa_pkg::asa_cmd_type cmd,
   output asa_pkg::asa_sts_type sts,
   output asa_pkg::asa_rsp_type rsp_data
);
   import asa_pkg::*;

   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_FULL = CNT_W'(MAX_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
   localparam logic [8:0]       HDR        = 9'(HEADER_BYTES);

   asa_req_type      req_ff;
   logic [16:0]      pool_ff;
   logic [16:0]      top_ff, top_in;
   logic [CNT_W-1:0] count_ff, count_in;
   asa_rsp_type      rsp_ff;

   // Entry stack: block address in the upper 16 bits, padding in the low 8
   logic [23:0]      mem [MAX_DEPTH];
   logic [23:0]      rd_ff;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic [23:0]      wr_data;

   logic [15:0] rd_addr;
   logic [7:0]  rd_pad;
   logic [16:0] pop_top;

   logic [7:0]  a_low, a_mask;
   logic [7:0]  p0;
   logic [8:0]  need, rounded, pad9;
   logic [17:0] blk, blk_end;

   assign rd_addr = rd_ff[23:8];
   assign rd_pad  = rd_ff[7:0];

   // Padding: forward to the alignment, then whole alignment steps up to the header
   always_comb begin
      a_low   = req_ff.alignment & (~req_ff.alignment + 8'd1);
      a_mask  = (a_low == 8'd0) ? 8'd0 : a_low - 8'd1;
      p0      = (~top_ff[7:0] + 8'd1) & a_mask;
      need    = HDR - {1'b0, p0};
      rounded = (need + {1'b0, a_mask}) & ~{1'b0, a_mask};
      pad9    = ({1'b0, p0} < HDR) ? {1'b0, p0} + rounded : {1'b0, p0};
      blk     = {1'b0, top_ff} + {9'd0, pad9};
      blk_end = blk + {2'd0, req_ff.size};
   end

   // Top offset after popping the entry under read
   assign pop_top = ({1'b0, rd_addr} >= {9'd0, rd_pad})
                    ? {1'b0, rd_addr} - {9'd0, rd_pad} : 17'd0;

   // Report conditions to the controller
   always_comb begin
      sts.kind      = req_ff.kind;
      sts.empty     = (count_ff == '0);
      sts.full      = (count_ff >= DEPTH_FULL);
      sts.last      = (count_ff == CNT_ONE);
      sts.oom       = (blk_end > {1'b0, pool_ff}) || (blk[17:16] != 2'd0);
      sts.top_match = (req_ff.address != 16'd0) && (req_ff.address == rd_addr);
      sts.pop_match = (rd_addr == req_ff.address);
   end

   // Next top and count
   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.push) begin
         top_in   = blk_end[16:0];
         count_in = count_ff + CNT_ONE;
      end else if (cmd.pop) begin
         top_in   = pop_top;
         count_in = count_ff - CNT_ONE;
      end
   end

   // Read always tracks the entry below the next count
   always_comb begin
      rd_idx  = IDX_W'(count_in - CNT_ONE);
      wr_idx  = IDX_W'(count_ff);
      wr_data = {blk[15:0], pad9[7:0]};
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= POOL_MAX;
         top_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write) begin
            pool_ff <= (csr_data > POOL_MAX) ? POOL_MAX : csr_data;
         end
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   // Latch request and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff.status <= cmd.status;
         unique case (cmd.addr_sel)
            SEL_ZERO:   rsp_ff.result_address <= 16'd0;
            SEL_ECHO:   rsp_ff.result_address <= req_ff.address;
            SEL_POPPED: rsp_ff.result_address <= rd_addr;
            SEL_BLOCK:  rsp_ff.result_address <= blk[15:0];
            default:    rsp_ff.result_address <= 16'd0;
         endcase
      end
   end

   // Entry stack memory with write-first read
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.push && (wr_idx == rd_idx)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_idx];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[src/asa_ctrl.sv]
// Controller of the aligned stack allocator: sequences each request and
// drives the datapath commands. Uses asa_pkg.
module asa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  asa_pkg::asa_sts_type sts,
   output asa_pkg::asa_cmd_type cmd
);
   import asa_pkg::*;

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Decide the action for the request in flight
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = SEL_ZERO;
      cmd.status   = ST_OK;
      state_in     = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = EXEC;
            end
         end
         EXEC: begin
            cmd.finish = 1'b1;
            unique case (sts.kind)
               KIND_ALLOC: begin
                  priority if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else if (sts.oom) begin
                     cmd.status = ST_OOM;
                  end else begin
                     cmd.push     = 1'b1;
                     cmd.addr_sel = SEL_BLOCK;
                  end
               end
               KIND_FREE: begin
                  priority if (sts.empty) begin
                     cmd.status   = ST_EMPTY;
                     cmd.addr_sel = SEL_ECHO;
                  end else if (!sts.top_match) begin
                     cmd.status   = ST_NOT_TOP;
                     cmd.addr_sel = SEL_ECHO;
                  end else begin
                     cmd.pop = 1'b1;
                  end
               end
               KIND_FAST: begin
                  if (sts.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.pop = 1'b1;
                     if (!sts.pop_match) begin
                        cmd.status   = ST_NOT_TOP;
                        cmd.addr_sel = SEL_POPPED;
                     end
                  end
               end
               KIND_ROLLBACK: begin
                  // Pop one entry a cycle until the named one or the bottom
                  if (sts.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.pop    = 1'b1;
                     cmd.finish = sts.pop_match || sts.last;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
               end
            endcase
            if (cmd.finish) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.finish;
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/aligned_stack_allocator_core.sv]
// Aligned stack allocator, top level: joins the controller and datapath.
// Depends on asa_pkg, asa_ctrl and asa_dpath.
//
// A request is taken when start is high and busy is low. Allocate, checked
// free and fast free pass through the execute state after the accepting
// edge, then the result shows for one cycle with rsp_valid, during which the
// next request may already be taken. A rollback stays in the execute state
// while it pops its entries one by one, since the entry stack memory has one
// read port and each pop reads the entry below it. Results cannot be
// stalled: rsp_valid lasts exactly one cycle and must be captured then. The
// entry stack needs no clearing after reset. Write csr_data (pool size,
// saturated to 65536) only while no request is open.
module aligned_stack_allocator_core #(
   parameter int MAX_DEPTH    = 64,
   parameter int HEADER_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  asa_pkg::asa_req_type req_data,
   output logic                 rsp_valid,
   output asa_pkg::asa_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [16:0]          csr_data
);
   import asa_pkg::*;

   asa_cmd_type cmd;
   asa_sts_type sts;

   // Configuration is always taken
   assign csr_ready = 1'b1;

   asa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   asa_dpath #(
      .MAX_DEPTH    (MAX_DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
